@@ hdl/fcu_pkg.sv @@
package fcu_pkg;

  localparam int unsigned ADDR_WIDTH_DEF   = 39;
  localparam int unsigned OFFSET_WIDTH_DEF = 6;
  localparam int unsigned COUNT_WIDTH_DEF  = 48;

  localparam int unsigned FLAG_WIDTH    = 7;
  localparam int unsigned COUNTER_WIDTH = 6;

  typedef enum logic {
    CMD_BEGIN  = 1'b0,
    CMD_RETIRE = 1'b1
  } cmd_t;

  // entry flag bit positions
  localparam int unsigned FL_VALID      = 0;
  localparam int unsigned FL_BR_VALID   = 1;
  localparam int unsigned FL_TAIL_VALID = 2;
  localparam int unsigned FL_TAIL_BR    = 3;
  localparam int unsigned FL_TOK_TAIL   = 4;
  localparam int unsigned FL_TOK        = 5;
  localparam int unsigned FL_FIRST      = 6;

  localparam logic [1:0] CTR_MAX  = 2'd3;
  localparam logic [1:0] CTR_ZERO = 2'd0;

  typedef struct packed {
    logic [1:0] br_ctr;
    logic [1:0] tail_ctr;
    logic       at_br;
    logic       at_tail;
  } slot_state_t;

endpackage

@@ hdl/fcu_if.sv @@
interface fcu_in_if #(
  parameter int unsigned ADDR_WIDTH   = fcu_pkg::ADDR_WIDTH_DEF,
  parameter int unsigned OFFSET_WIDTH = fcu_pkg::OFFSET_WIDTH_DEF
);
  logic                              valid;
  logic                              ready;
  logic                              cmd;
  logic [ADDR_WIDTH-1:0]             pc;
  logic [ADDR_WIDTH-1:0]             target;
  logic [OFFSET_WIDTH-1:0]           br_offset;
  logic [OFFSET_WIDTH-1:0]           tail_offset;
  logic [fcu_pkg::FLAG_WIDTH-1:0]    entry_flags;
  logic [fcu_pkg::COUNTER_WIDTH-1:0] entry_counters;
  logic                              is_rvc;
  logic                              is_jump;
  logic                              is_halt;

  modport source (
    output valid, cmd, pc, target, br_offset, tail_offset, entry_flags,
           entry_counters, is_rvc, is_jump, is_halt,
    input  ready
  );
  modport sink (
    input  valid, cmd, pc, target, br_offset, tail_offset, entry_flags,
           entry_counters, is_rvc, is_jump, is_halt,
    output ready
  );
endinterface

interface fcu_out_if #(
  parameter int unsigned ADDR_WIDTH  = fcu_pkg::ADDR_WIDTH_DEF,
  parameter int unsigned COUNT_WIDTH = fcu_pkg::COUNT_WIDTH_DEF
);
  logic                   valid;
  logic                   ready;
  logic [1:0]             br_counter;
  logic [1:0]             tail_counter;
  logic [1:0]             always_taken_bits;
  logic                   mispredict;
  logic [ADDR_WIDTH-1:0]  redirect_pc;
  logic                   block_closed;
  logic                   halted;
  logic [COUNT_WIDTH-1:0] retired_count;
  logic [COUNT_WIDTH-1:0] miss_count;

  modport source (
    output valid, br_counter, tail_counter, always_taken_bits, mispredict,
           redirect_pc, block_closed, halted, retired_count, miss_count,
    input  ready
  );
  modport sink (
    input  valid, br_counter, tail_counter, always_taken_bits, mispredict,
           redirect_pc, block_closed, halted, retired_count, miss_count,
    output ready
  );
endinterface

@@ hdl/fcu_in_stage.sv @@
module fcu_in_stage (
  input  logic      clk,
  input  logic      rst,
  fcu_in_if.sink    item,
  fcu_in_if.source  staged
);

  logic valid;
  logic valid_next;
  logic take;

  assign item.ready = !valid || staged.ready;
  assign take       = item.valid && item.ready;

  always_comb begin
    valid_next = valid;
    if (take) begin
      valid_next = 1'b1;
    end else if (staged.ready) begin
      valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      staged.cmd            <= item.cmd;
      staged.pc             <= item.pc;
      staged.target         <= item.target;
      staged.br_offset      <= item.br_offset;
      staged.tail_offset    <= item.tail_offset;
      staged.entry_flags    <= item.entry_flags;
      staged.entry_counters <= item.entry_counters;
      staged.is_rvc         <= item.is_rvc;
      staged.is_jump        <= item.is_jump;
      staged.is_halt        <= item.is_halt;
    end
  end

  assign staged.valid = valid;

endmodule

@@ hdl/fcu_core.sv @@
module fcu_core #(
  parameter int unsigned ADDR_WIDTH   = fcu_pkg::ADDR_WIDTH_DEF,
  parameter int unsigned OFFSET_WIDTH = fcu_pkg::OFFSET_WIDTH_DEF,
  parameter int unsigned COUNT_WIDTH  = fcu_pkg::COUNT_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  fcu_in_if.sink    staged,
  fcu_out_if.source res
);

  logic [ADDR_WIDTH-1:0]          block_start;
  logic [ADDR_WIDTH-1:0]          predicted_next;
  logic [OFFSET_WIDTH-1:0]        br_off;
  logic [OFFSET_WIDTH-1:0]        tail_off;
  logic [fcu_pkg::FLAG_WIDTH-1:0] flag_bits;
  fcu_pkg::slot_state_t           slots;
  logic                           closed_flag;
  logic                           halt_flag;
  logic [COUNT_WIDTH-1:0]         inst_total;
  logic [COUNT_WIDTH-1:0]         miss_total;

  logic [ADDR_WIDTH-1:0]          block_start_next;
  logic [ADDR_WIDTH-1:0]          predicted_next_next;
  logic [OFFSET_WIDTH-1:0]        br_off_next;
  logic [OFFSET_WIDTH-1:0]        tail_off_next;
  logic [fcu_pkg::FLAG_WIDTH-1:0] flag_bits_next;
  fcu_pkg::slot_state_t           slots_next;
  logic                           closed_flag_next;
  logic                           halt_flag_next;
  logic [COUNT_WIDTH-1:0]         inst_total_next;
  logic [COUNT_WIDTH-1:0]         miss_total_next;

  logic                  fire;
  logic [ADDR_WIDTH-1:0] off;
  logic                  at_tok;
  logic                  br_hit;
  logic                  tail_hit;
  logic                  f_valid, f_br_valid, f_tail_valid, f_tail_br;
  logic                  f_tok_tail, f_tok, f_first;
  logic                  miss;
  logic [ADDR_WIDTH-1:0] redirect;

  assign fire         = staged.valid && res.ready;
  assign staged.ready = res.ready;
  assign res.valid    = staged.valid;

  assign f_valid      = flag_bits[fcu_pkg::FL_VALID];
  assign f_br_valid   = flag_bits[fcu_pkg::FL_BR_VALID];
  assign f_tail_valid = flag_bits[fcu_pkg::FL_TAIL_VALID];
  assign f_tail_br    = flag_bits[fcu_pkg::FL_TAIL_BR];
  assign f_tok_tail   = flag_bits[fcu_pkg::FL_TOK_TAIL];
  assign f_tok        = flag_bits[fcu_pkg::FL_TOK];
  assign f_first      = flag_bits[fcu_pkg::FL_FIRST];

  assign off      = staged.pc - block_start;
  assign at_tok   = off == (f_tok_tail ? ADDR_WIDTH'(tail_off) : ADDR_WIDTH'(br_off));
  assign br_hit   = f_valid && f_br_valid && (off == ADDR_WIDTH'(br_off));
  assign tail_hit = f_valid && f_tail_valid && (off == ADDR_WIDTH'(tail_off));

  always_comb begin
    block_start_next    = block_start;
    predicted_next_next = predicted_next;
    br_off_next         = br_off;
    tail_off_next       = tail_off;
    flag_bits_next      = flag_bits;
    slots_next          = slots;
    closed_flag_next    = closed_flag;
    halt_flag_next      = halt_flag;
    inst_total_next     = inst_total;
    miss_total_next     = miss_total;
    miss                = 1'b0;
    redirect            = '0;
    priority if (halt_flag) begin
    end else if (staged.cmd == fcu_pkg::CMD_BEGIN) begin
      block_start_next    = staged.pc;
      predicted_next_next = staged.target;
      br_off_next         = staged.br_offset;
      tail_off_next       = staged.tail_offset;
      flag_bits_next      = staged.entry_flags;
      slots_next          = fcu_pkg::slot_state_t'({staged.entry_counters[1:0],
                                                    staged.entry_counters[3:2],
                                                    staged.entry_counters[4],
                                                    staged.entry_counters[5]});
      closed_flag_next    = 1'b0;
    end else if (staged.is_halt) begin
      halt_flag_next = 1'b1;
    end else if (closed_flag) begin
    end else begin
      inst_total_next = inst_total + COUNT_WIDTH'(1);
      if (br_hit) begin
        priority if (f_first && staged.is_jump) begin
          slots_next.br_ctr  = fcu_pkg::CTR_MAX;
          slots_next.at_br   = 1'b1;
          slots_next.at_tail = 1'b0;
        end else if (f_first) begin
          slots_next.br_ctr = fcu_pkg::CTR_ZERO;
          slots_next.at_br  = 1'b0;
        end else if (at_tok && f_tok && staged.is_jump) begin
          if (slots.br_ctr != fcu_pkg::CTR_MAX && !slots.at_br) begin
            slots_next.br_ctr = slots.br_ctr + 2'd1;
          end
        end else if (at_tok && f_tok) begin
          if (slots.br_ctr != fcu_pkg::CTR_ZERO) begin
            slots_next.br_ctr = slots.br_ctr - 2'd1;
          end
          slots_next.at_br = 1'b0;
        end else if (staged.is_jump) begin
          if (slots.br_ctr != fcu_pkg::CTR_MAX) begin
            slots_next.br_ctr = slots.br_ctr + 2'd1;
          end
        end else begin
        end
      end else if (tail_hit) begin
        priority if (f_first && staged.is_jump && f_tail_br) begin
          slots_next.tail_ctr = fcu_pkg::CTR_MAX;
          slots_next.at_tail  = 1'b1;
        end else if (f_first) begin
          slots_next.tail_ctr = fcu_pkg::CTR_ZERO;
          slots_next.at_tail  = 1'b0;
        end else if (at_tok && f_tok && staged.is_jump) begin
          if (slots.tail_ctr != fcu_pkg::CTR_MAX && !slots.at_tail && f_tail_br) begin
            slots_next.tail_ctr = slots.tail_ctr + 2'd1;
          end
        end else if (at_tok && f_tok) begin
          if (slots.tail_ctr != fcu_pkg::CTR_ZERO) begin
            slots_next.tail_ctr = slots.tail_ctr - 2'd1;
          end
          slots_next.at_tail = 1'b0;
        end else if (!f_tok && staged.is_jump) begin
          if (slots.tail_ctr != fcu_pkg::CTR_MAX) begin
            slots_next.tail_ctr = slots.tail_ctr + 2'd1;
          end
        end else begin
        end
      end
      if (staged.is_jump) begin
        if (!f_tok || predicted_next != staged.target) begin
          miss     = 1'b1;
          redirect = staged.target;
        end
        closed_flag_next = 1'b1;
      end else if (at_tok && f_tok) begin
        miss     = 1'b1;
        redirect = staged.pc + (staged.is_rvc ? ADDR_WIDTH'(2) : ADDR_WIDTH'(4));
      end
      if (miss) begin
        miss_total_next = miss_total + COUNT_WIDTH'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_start    <= '0;
      predicted_next <= '0;
      br_off         <= '0;
      tail_off       <= '0;
      flag_bits      <= '0;
      slots          <= '0;
      closed_flag    <= 1'b0;
      halt_flag      <= 1'b0;
      inst_total     <= '0;
      miss_total     <= '0;
    end else if (fire) begin
      block_start    <= block_start_next;
      predicted_next <= predicted_next_next;
      br_off         <= br_off_next;
      tail_off       <= tail_off_next;
      flag_bits      <= flag_bits_next;
      slots          <= slots_next;
      closed_flag    <= closed_flag_next;
      halt_flag      <= halt_flag_next;
      inst_total     <= inst_total_next;
      miss_total     <= miss_total_next;
    end
  end

  assign res.br_counter        = slots_next.br_ctr;
  assign res.tail_counter      = slots_next.tail_ctr;
  assign res.always_taken_bits = {slots_next.at_tail, slots_next.at_br};
  assign res.mispredict        = miss;
  assign res.redirect_pc       = redirect;
  assign res.block_closed      = closed_flag_next;
  assign res.halted            = halt_flag_next;
  assign res.retired_count     = inst_total_next;
  assign res.miss_count        = miss_total_next;

endmodule

@@ hdl/fcu_out_stage.sv @@
module fcu_out_stage (
  input  logic      clk,
  input  logic      rst,
  fcu_out_if.sink   res,
  fcu_out_if.source result
);

  logic valid;
  logic valid_next;
  logic take;

  assign res.ready = !valid || result.ready;
  assign take      = res.valid && res.ready;

  always_comb begin
    valid_next = valid;
    if (take) begin
      valid_next = 1'b1;
    end else if (result.ready) begin
      valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result.br_counter        <= res.br_counter;
      result.tail_counter      <= res.tail_counter;
      result.always_taken_bits <= res.always_taken_bits;
      result.mispredict        <= res.mispredict;
      result.redirect_pc       <= res.redirect_pc;
      result.block_closed      <= res.block_closed;
      result.halted            <= res.halted;
      result.retired_count     <= res.retired_count;
      result.miss_count        <= res.miss_count;
    end
  end

  assign result.valid = valid;

endmodule

@@ hdl/ftb_commit_update.sv @@
// Commit-side update of one fetch-target-buffer entry (branch slot and tail
// slot). A begin word loads the predicted entry; each retire word, until a
// jump closes the block, steps the matching slot's 2-bit counter and
// always-taken bit and reports a mispredict with its restart pc, together
// with running instruction and miss counts. Takes one word every cycle
// unless the result side stalls; a word passes the input register, one pass
// of update logic and the result register. Both sides may stall freely
// without loss of throughput. A halt word freezes all state until reset.
module ftb_commit_update #(
  parameter int unsigned ADDR_WIDTH   = fcu_pkg::ADDR_WIDTH_DEF,
  parameter int unsigned OFFSET_WIDTH = fcu_pkg::OFFSET_WIDTH_DEF,
  parameter int unsigned COUNT_WIDTH  = fcu_pkg::COUNT_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  fcu_in_if.sink    item,
  fcu_out_if.source result
);

  fcu_in_if #(
    .ADDR_WIDTH   (ADDR_WIDTH),
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) staged ();

  fcu_out_if #(
    .ADDR_WIDTH  (ADDR_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) res ();

  fcu_in_stage u_in_stage (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .staged (staged)
  );

  fcu_core #(
    .ADDR_WIDTH   (ADDR_WIDTH),
    .OFFSET_WIDTH (OFFSET_WIDTH),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .staged (staged),
    .res    (res)
  );

  fcu_out_stage u_out_stage (
    .clk    (clk),
    .rst    (rst),
    .res    (res),
    .result (result)
  );

endmodule

@@ sim/fcu_result_monitor.sv @@
`timescale 1ns / 100ps

module fcu_result_monitor (
  input  logic clk,
  input  logic rst,
  fcu_in_if    item_mon,
  fcu_out_if   result_mon,
  output int   fail_count,
  output int   pending
);

  import fcu_pkg::*;

  localparam int unsigned AW = ADDR_WIDTH_DEF;
  localparam int unsigned OW = OFFSET_WIDTH_DEF;
  localparam int unsigned CW = COUNT_WIDTH_DEF;

  typedef struct packed {
    logic [1:0]    br_ctr;
    logic [1:0]    tail_ctr;
    logic [1:0]    at_bits;
    logic          miss;
    logic [AW-1:0] redirect;
    logic          closed;
    logic          halted;
    logic [CW-1:0] retired;
    logic [CW-1:0] misses;
  } commit_result_t;

  commit_result_t expected_updates[$];

  // mirror of the entry under update
  logic [AW-1:0]         blk_start;
  logic [AW-1:0]         pred_next;
  logic [OW-1:0]         br_off;
  logic [OW-1:0]         tl_off;
  logic [FLAG_WIDTH-1:0] flags;
  logic [1:0]            bc;
  logic [1:0]            tc;
  logic                  at0;
  logic                  at1;
  logic                  closed;
  logic                  halted;
  logic [CW-1:0]         inst_total;
  logic [CW-1:0]         miss_total;
  int                    errors = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got_v,
                                 input logic [63:0] want_v);
    $display("mismatch %s: got %0h want %0h at %0t", what, got_v, want_v, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    logic [AW-1:0]  pc_w;
    logic [AW-1:0]  tgt_w;
    logic [AW-1:0]  off;
    logic [AW-1:0]  redir;
    logic [OW-1:0]  tok_off;
    logic           miss;
    logic           at_tok;
    logic           jump;
    logic           tok;
    logic           first;
    commit_result_t want;
    commit_result_t got;
    if (rst) begin
      blk_start = '0;
      pred_next = '0;
      br_off = '0;
      tl_off = '0;
      flags = '0;
      bc = CTR_ZERO;
      tc = CTR_ZERO;
      at0 = 1'b0;
      at1 = 1'b0;
      closed = 1'b0;
      halted = 1'b0;
      inst_total = '0;
      miss_total = '0;
      expected_updates.delete();
    end else begin
      if (item_mon.valid && item_mon.ready) begin
        miss = 1'b0;
        redir = '0;
        if (!halted) begin
          if (item_mon.cmd == CMD_BEGIN) begin
            blk_start = item_mon.pc;
            pred_next = item_mon.target;
            br_off = item_mon.br_offset;
            tl_off = item_mon.tail_offset;
            flags = item_mon.entry_flags;
            {at1, at0, tc, bc} = item_mon.entry_counters;
            closed = 1'b0;
          end else if (item_mon.is_halt) begin
            halted = 1'b1;
          end else if (!closed) begin
            pc_w = item_mon.pc;
            tgt_w = item_mon.target;
            jump = item_mon.is_jump;
            tok = flags[FL_TOK];
            first = flags[FL_FIRST];
            off = pc_w - blk_start;
            tok_off = flags[FL_TOK_TAIL] ? tl_off : br_off;
            at_tok = (off == AW'(tok_off));
            inst_total = inst_total + CW'(1);
            if (flags[FL_VALID] && flags[FL_BR_VALID] && off == AW'(br_off)) begin
              if (first && jump) begin
                bc = CTR_MAX;
                at0 = 1'b1;
                at1 = 1'b0;
              end else if (first) begin
                bc = CTR_ZERO;
                at0 = 1'b0;
              end else if (at_tok && tok && jump) begin
                if (bc != CTR_MAX && !at0) bc = bc + 2'd1;
              end else if (at_tok && tok) begin
                if (bc != CTR_ZERO) bc = bc - 2'd1;
                at0 = 1'b0;
              end else if (jump) begin
                if (bc != CTR_MAX) bc = bc + 2'd1;
              end
            end else if (flags[FL_VALID] && flags[FL_TAIL_VALID] && off == AW'(tl_off)) begin
              if (first && jump && flags[FL_TAIL_BR]) begin
                tc = CTR_MAX;
                at1 = 1'b1;
              end else if (first) begin
                tc = CTR_ZERO;
                at1 = 1'b0;
              end else if (at_tok && tok && jump) begin
                if (tc != CTR_MAX && !at1 && flags[FL_TAIL_BR]) tc = tc + 2'd1;
              end else if (at_tok && tok) begin
                if (tc != CTR_ZERO) tc = tc - 2'd1;
                at1 = 1'b0;
              end else if (!tok && jump) begin
                if (tc != CTR_MAX) tc = tc + 2'd1;
              end
            end
            if (jump) begin
              if (!tok || pred_next != tgt_w) begin
                miss = 1'b1;
                redir = tgt_w;
              end
              closed = 1'b1;
            end else if (at_tok && tok) begin
              miss = 1'b1;
              redir = pc_w + (item_mon.is_rvc ? AW'(2) : AW'(4));
            end
            if (miss) miss_total = miss_total + CW'(1);
          end
        end
        want.br_ctr = bc;
        want.tail_ctr = tc;
        want.at_bits = {at1, at0};
        want.miss = miss;
        want.redirect = redir;
        want.closed = closed;
        want.halted = halted;
        want.retired = inst_total;
        want.misses = miss_total;
        expected_updates.push_back(want);
      end

      if (result_mon.valid && result_mon.ready) begin
        got.br_ctr = result_mon.br_counter;
        got.tail_ctr = result_mon.tail_counter;
        got.at_bits = result_mon.always_taken_bits;
        got.miss = result_mon.mispredict;
        got.redirect = result_mon.redirect_pc;
        got.closed = result_mon.block_closed;
        got.halted = result_mon.halted;
        got.retired = result_mon.retired_count;
        got.misses = result_mon.miss_count;
        if (expected_updates.size() == 0) begin
          report_mismatch("word with nothing expected", 64'd0, 64'd0);
        end else begin
          want = expected_updates.pop_front();
          if (got.br_ctr !== want.br_ctr)
            report_mismatch("br_counter", 64'(got.br_ctr), 64'(want.br_ctr));
          if (got.tail_ctr !== want.tail_ctr)
            report_mismatch("tail_counter", 64'(got.tail_ctr), 64'(want.tail_ctr));
          if (got.at_bits !== want.at_bits)
            report_mismatch("always_taken_bits", 64'(got.at_bits), 64'(want.at_bits));
          if (got.miss !== want.miss)
            report_mismatch("mispredict", 64'(got.miss), 64'(want.miss));
          if (got.redirect !== want.redirect)
            report_mismatch("redirect_pc", 64'(got.redirect), 64'(want.redirect));
          if (got.closed !== want.closed)
            report_mismatch("block_closed", 64'(got.closed), 64'(want.closed));
          if (got.halted !== want.halted)
            report_mismatch("halted", 64'(got.halted), 64'(want.halted));
          if (got.retired !== want.retired)
            report_mismatch("retired_count", 64'(got.retired), 64'(want.retired));
          if (got.misses !== want.misses)
            report_mismatch("miss_count", 64'(got.misses), 64'(want.misses));
        end
      end
    end
    pending <= expected_updates.size();
    fail_count <= errors;
  end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

  import fcu_pkg::*;

  localparam int unsigned AW = ADDR_WIDTH_DEF;
  localparam int unsigned OW = OFFSET_WIDTH_DEF;
  localparam int          RANDOM_WORDS = 1200;
  localparam int          IDLE_LIMIT = 3000;
  localparam int          HOLD_CYCLES = 400;
  localparam logic [AW-1:0] PC_MAX = '1;

  typedef struct {
    cmd_t                     cmd;
    logic [AW-1:0]            pc;
    logic [AW-1:0]            target;
    logic [OW-1:0]            br_off;
    logic [OW-1:0]            tail_off;
    logic [FLAG_WIDTH-1:0]    flags;
    logic [COUNTER_WIDTH-1:0] ctrs;
    logic                     rvc;
    logic                     jump;
    logic                     halt;
  } commit_word_t;

  logic clk;
  logic rst;
  int   mon_fails;
  int   mon_pending;
  int   words_sent;
  int   rx_words;
  int   idle_cycles;
  bit   tx_burst;
  bit   rx_burst;
  bit   held;

  fcu_in_if  item_ch ();
  fcu_out_if result_ch ();

  ftb_commit_update u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  fcu_result_monitor u_monitor (
    .clk        (clk),
    .rst        (rst),
    .item_mon   (item_ch),
    .result_mon (result_ch),
    .fail_count (mon_fails),
    .pending    (mon_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [AW-1:0] rand_addr();
    logic [63:0] r;
    case ($urandom_range(0, 15))
      0: r = '0;
      1: r = '1;
      default: r = {$urandom, $urandom};
    endcase
    return r[AW-1:0];
  endfunction

  function automatic logic [FLAG_WIDTH-1:0] flags_of(input bit valid, input bit br_valid,
      input bit tail_valid, input bit tail_br, input bit tok_tail, input bit tok,
      input bit first);
    logic [FLAG_WIDTH-1:0] f;
    f = '0;
    f[FL_VALID] = valid;
    f[FL_BR_VALID] = br_valid;
    f[FL_TAIL_VALID] = tail_valid;
    f[FL_TAIL_BR] = tail_br;
    f[FL_TOK_TAIL] = tok_tail;
    f[FL_TOK] = tok;
    f[FL_FIRST] = first;
    return f;
  endfunction

  function automatic logic [COUNTER_WIDTH-1:0] ctrs_of(input logic [1:0] bc,
      input logic [1:0] tc, input bit at0, input bit at1);
    return {at1, at0, tc, bc};
  endfunction

  task automatic send_word(input commit_word_t w);
    int gap;
    if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 16);
    repeat (gap) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.cmd <= w.cmd;
    item_ch.pc <= w.pc;
    item_ch.target <= w.target;
    item_ch.br_offset <= w.br_off;
    item_ch.tail_offset <= w.tail_off;
    item_ch.entry_flags <= w.flags;
    item_ch.entry_counters <= w.ctrs;
    item_ch.is_rvc <= w.rvc;
    item_ch.is_jump <= w.jump;
    item_ch.is_halt <= w.halt;
    do @(posedge clk); while (!item_ch.ready);
    words_sent++;
  endtask

  // begin word: retire-only bits are don't-care noise
  task automatic send_begin(input logic [AW-1:0] pc, input logic [AW-1:0] nxt,
      input logic [OW-1:0] bo, input logic [OW-1:0] to,
      input logic [FLAG_WIDTH-1:0] fl, input logic [COUNTER_WIDTH-1:0] ct);
    commit_word_t w;
    w.cmd = CMD_BEGIN;
    w.pc = pc;
    w.target = nxt;
    w.br_off = bo;
    w.tail_off = to;
    w.flags = fl;
    w.ctrs = ct;
    w.rvc = 1'($urandom_range(0, 1));
    w.jump = 1'($urandom_range(0, 1));
    w.halt = 1'($urandom_range(0, 1));
    send_word(w);
  endtask

  // retire word: entry fields are don't-care noise
  task automatic send_retire(input logic [AW-1:0] pc, input logic [AW-1:0] tgt,
      input logic rvc, input logic jump, input logic halt);
    commit_word_t w;
    w.cmd = CMD_RETIRE;
    w.pc = pc;
    w.target = tgt;
    w.br_off = OW'($urandom_range(0, 63));
    w.tail_off = OW'($urandom_range(0, 63));
    w.flags = FLAG_WIDTH'($urandom_range(0, 127));
    w.ctrs = COUNTER_WIDTH'($urandom_range(0, 63));
    w.rvc = rvc;
    w.jump = jump;
    w.halt = halt;
    send_word(w);
  endtask

  // receiver with one long hold-off to back the block up
  initial begin
    int stall;
    result_ch.ready <= 1'b0;
    rx_words = 0;
    rx_burst = 1'b0;
    held = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, 16);
      if (!held && rx_words >= 150) begin
        held = 1'b1;
        stall = HOLD_CYCLES;
      end
      repeat (stall) begin
        result_ch.ready <= 1'b0;
        @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
      rx_words++;
    end
  end

  // watchdog on cycles with no handshake on either side
  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    logic [AW-1:0]         blk_pc;
    logic [AW-1:0]         blk_nxt;
    logic [OW-1:0]         bo;
    logic [OW-1:0]         to;
    logic [OW-1:0]         tok_off;
    logic [OW-1:0]         other_off;
    logic [OW-1:0]         off;
    logic [FLAG_WIDTH-1:0] fl;
    logic                  jmp;
    int                    sel;
    int                    n;
    words_sent = 0;
    tx_burst = 1'b0;
    rst <= 1'b1;
    item_ch.valid <= 1'b0;
    item_ch.cmd <= CMD_BEGIN;
    item_ch.pc <= '0;
    item_ch.target <= '0;
    item_ch.br_offset <= '0;
    item_ch.tail_offset <= '0;
    item_ch.entry_flags <= '0;
    item_ch.entry_counters <= '0;
    item_ch.is_rvc <= 1'b0;
    item_ch.is_jump <= 1'b0;
    item_ch.is_halt <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // retire before any begin, then a jump, then a retire on a closed block
    send_retire('0, '0, 1'b0, 1'b0, 1'b0);
    send_retire('0, PC_MAX, 1'b0, 1'b1, 1'b0);
    send_retire('0, '0, 1'b1, 1'b0, 1'b0);
    // all-ones entry, wrapped offset, first prediction on a jump
    send_begin(PC_MAX, PC_MAX, '1, '1, '1, '1);
    send_retire(PC_MAX + AW'(63), PC_MAX, 1'b0, 1'b1, 1'b0);
    // taken branch slot not taken, compressed and full length
    send_begin('0, AW'(39'h1000), 6'd4, 6'd12,
               flags_of(1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0),
               ctrs_of(2'd1, 2'd2, 1'b0, 1'b0));
    send_retire('0, '0, 1'b0, 1'b0, 1'b0);
    send_retire(AW'(4), '0, 1'b1, 1'b0, 1'b0);
    send_retire(AW'(4), '0, 1'b0, 1'b0, 1'b0);
    send_retire(AW'(12), AW'(39'h1000), 1'b0, 1'b1, 1'b0);
    // wrong jump target at a saturated branch slot
    send_begin(AW'(39'h100), AW'(39'h200), 6'd8, 6'd16,
               flags_of(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0),
               ctrs_of(2'd3, 2'd3, 1'b1, 1'b0));
    send_retire(AW'(39'h108), AW'(39'h300), 1'b0, 1'b1, 1'b0);
    // not-taken prediction, tail jumps
    send_begin(AW'(39'h100), AW'(39'h200), 6'd8, 6'd16,
               flags_of(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0),
               ctrs_of(2'd0, 2'd0, 1'b0, 1'b0));
    send_retire(AW'(39'h110), AW'(39'h200), 1'b0, 1'b1, 1'b0);
    // correct taken tail jump steps counter
    send_begin(AW'(39'h100), AW'(39'h200), 6'd8, 6'd16,
               flags_of(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0),
               ctrs_of(2'd0, 2'd1, 1'b0, 1'b0));
    send_retire(AW'(39'h110), AW'(39'h200), 1'b0, 1'b1, 1'b0);
    // restart pc wraps past the top of the address space
    send_begin(PC_MAX - AW'(1), '0, 6'd2, 6'd0,
               flags_of(1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0),
               ctrs_of(2'd0, 2'd2, 1'b0, 1'b1));
    send_retire(PC_MAX - AW'(1), '0, 1'b0, 1'b0, 1'b0);
    send_retire('0, '0, 1'b1, 1'b0, 1'b0);
    // first prediction at a non-branch tail
    send_begin(AW'(39'h40), AW'(39'h80), 6'd0, 6'd6,
               flags_of(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1), '1);
    send_retire(AW'(39'h46), AW'(39'h2000), 1'b0, 1'b1, 1'b0);
    // first prediction at the branch slot, not taken
    send_begin(AW'(39'h40), AW'(39'h80), 6'd0, 6'd6,
               flags_of(1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1), '1);
    send_retire(AW'(39'h40), AW'(39'h80), 1'b1, 1'b0, 1'b0);

    while (words_sent < RANDOM_WORDS + 22) begin
      blk_pc = rand_addr();
      blk_nxt = ($urandom_range(0, 3) == 0) ? blk_pc + AW'($urandom_range(0, 63)) : rand_addr();
      bo = OW'($urandom_range(0, 63));
      to = ($urandom_range(0, 15) == 0) ? bo : OW'($urandom_range(0, 63));
      fl = FLAG_WIDTH'($urandom_range(0, 127));
      fl[FL_VALID] = ($urandom_range(0, 9) != 0);
      fl[FL_FIRST] = ($urandom_range(0, 3) == 0);
      send_begin(blk_pc, blk_nxt, bo, to, fl, COUNTER_WIDTH'($urandom_range(0, 63)));
      tok_off = fl[FL_TOK_TAIL] ? to : bo;
      other_off = fl[FL_TOK_TAIL] ? bo : to;
      n = $urandom_range(1, 6);
      repeat (n) begin
        sel = $urandom_range(0, 19);
        if (sel < 8) off = tok_off;
        else if (sel < 13) off = other_off;
        else off = OW'($urandom_range(0, 63));
        jmp = (sel < 8) ? ($urandom_range(0, 9) < 6) : ($urandom_range(0, 4) == 0);
        send_retire(blk_pc + AW'(off), $urandom_range(0, 1) ? blk_nxt : rand_addr(),
                    1'($urandom_range(0, 1)), jmp, 1'b0);
      end
      if ($urandom_range(0, 9) == 0)
        send_retire(rand_addr(), rand_addr(), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 1'b0);
    end

    // halt on a closed block, then everything is frozen
    send_retire(rand_addr(), rand_addr(), 1'b0, 1'b1, 1'b0);
    send_retire(rand_addr(), rand_addr(), 1'b0, 1'b0, 1'b1);
    send_begin(rand_addr(), rand_addr(), OW'($urandom_range(0, 63)),
               OW'($urandom_range(0, 63)), FLAG_WIDTH'($urandom_range(0, 127)),
               COUNTER_WIDTH'($urandom_range(0, 63)));
    send_retire(rand_addr(), rand_addr(), 1'b1, 1'b1, 1'b0);
    send_retire(rand_addr(), rand_addr(), 1'b0, 1'b0, 1'b1);
    item_ch.valid <= 1'b0;

    @(posedge clk);
    while (mon_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mon_fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/fcu_pkg.sv
hdl/fcu_if.sv
hdl/fcu_in_stage.sv
hdl/fcu_core.sv
hdl/fcu_out_stage.sv
hdl/ftb_commit_update.sv
sim/fcu_result_monitor.sv
sim/testbench.sv
